// File: rtl/core/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared constants, codes and command/status types of the voxel face culler.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int unsigned CHUNK_WIDTH  = 16;
  localparam int unsigned CHUNK_DEPTH  = 16;
  localparam int unsigned CHUNK_HEIGHT = 16;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned TYPE_W      = 8;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned FACE_W      = 3;
  localparam int unsigned NUM_FACES   = 6;

  localparam int unsigned LAYER        = CHUNK_WIDTH * CHUNK_DEPTH;
  localparam int unsigned CHUNK_VOXELS = LAYER * CHUNK_HEIGHT;

  // Reciprocal division: exact for 12-bit dividends and divisors up to 64.
  localparam int unsigned DIV_SH  = 20;
  localparam int unsigned PROD_W  = IDX_W + DIV_SH;
  localparam int unsigned RECIP_W = ((1 << DIV_SH) + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
  localparam int unsigned RECIP_D = ((1 << DIV_SH) + CHUNK_DEPTH - 1) / CHUNK_DEPTH;

  // Neighbor address arithmetic: a sign bit and a carry bit over the store range.
  localparam int unsigned NB_W = IDX_W + 2;

  // Read sequence: center first, then the six neighbors in face order.
  localparam int unsigned NUM_READS  = NUM_FACES + 1;
  localparam int unsigned DONE_STEP  = NUM_READS + 1;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned STEP_W     = 3;

  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd0;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd1;
  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd2;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd3;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd4;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_EMIT
  } vfc_state_t;

  typedef struct packed {
    logic              load;     // capture the input word
    logic              work;     // read sequence active
    logic [STEP_W-1:0] step;     // read step in the sequence
    logic              finish;   // all reads in, build the face mask
    logic              advance;  // record taken, drop its face
  } vfc_cmd_t;

  typedef struct packed {
    logic last;
  } vfc_status_t;

  // Linear offset of the voxel read at each step of the sequence.
  function automatic int nb_offset(logic [STEP_W-1:0] step);
    int off;
    off = 0;
    case (step)
      3'd1:    off = -1;
      3'd2:    off = 1;
      3'd3:    off = -int'(CHUNK_WIDTH);
      3'd4:    off = int'(CHUNK_WIDTH);
      3'd5:    off = int'(LAYER);
      3'd6:    off = -int'(LAYER);
      default: off = 0;
    endcase
    return off;
  endfunction

endpackage

// File: rtl/core/vfc_in_if.sv
// ----------------------------------------------------------------------------
// vfc_in_if
// Input channel: write or query word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vfc_in_if
  import vfc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [IDX_W-1:0]  voxel_index;
  logic [TYPE_W-1:0] voxel_type;

  modport source (output valid, mode, voxel_index, voxel_type, input ready);
  modport sink   (input valid, mode, voxel_index, voxel_type, output ready);
endinterface

// File: rtl/core/vfc_out_if.sv
// ----------------------------------------------------------------------------
// vfc_out_if
// Output channel: one face record per word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vfc_out_if
  import vfc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              face_valid;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [POS_W-1:0]  pos_z;
  logic [FACE_W-1:0] face_id;
  logic [TYPE_W-1:0] texture_id;
  logic              last_face;

  modport source (output valid, face_valid, pos_x, pos_y, pos_z, face_id, texture_id,
                  last_face, input ready);
  modport sink   (input valid, face_valid, pos_x, pos_y, pos_z, face_id, texture_id,
                  last_face, output ready);
endinterface

// File: rtl/core/vfc_ctrl.sv
// ----------------------------------------------------------------------------
// vfc_ctrl
// Sequencer: accepts a word, steps the store reads, then hands out records.
// ----------------------------------------------------------------------------
module vfc_ctrl
  import vfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  vfc_status_t status,
  output vfc_cmd_t    cmd
);

  vfc_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DONE_STEP)) begin
          state_next = ST_EMIT;
          cnt_next   = '0;
        end
      end
      ST_EMIT: begin
        if (out_ready && status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    cmd.step    = cnt[STEP_W-1:0];
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_WORK: begin
        cmd.work   = (cnt < CNT_W'(NUM_READS));
        cmd.finish = (cnt == CNT_W'(DONE_STEP));
      end
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/vfc_datapath.sv
// ----------------------------------------------------------------------------
// vfc_datapath
// Voxel store, neighbor reads, coordinate split and face record build.
// ----------------------------------------------------------------------------
module vfc_datapath
  import vfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  vfc_cmd_t          cmd,
  output vfc_status_t       status,
  input  logic              in_mode,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [TYPE_W-1:0] in_type,
  output logic              face_valid,
  output logic [POS_W-1:0]  pos_x,
  output logic [POS_W-1:0]  pos_y,
  output logic [POS_W-1:0]  pos_z,
  output logic [FACE_W-1:0] face_id,
  output logic [TYPE_W-1:0] texture_id,
  output logic              last_face
);

  logic [TYPE_W-1:0] mem [STORE_DEPTH];

  logic              mode_r;
  logic [IDX_W-1:0]  idx_r;
  logic [TYPE_W-1:0] type_r;
  logic [TYPE_W-1:0] center;
  logic [NUM_FACES-1:0] empty;
  logic [NUM_FACES-1:0] pend;

  logic [TYPE_W-1:0] rd_data;
  logic [STEP_W-1:0] prev_step;
  logic              prev_ok;
  logic              prev_vld;

  logic [PROD_W-1:0] prod_w, prod_d;
  logic [IDX_W-1:0]  q_row, x_r, y_r, z_r;

  logic signed [NB_W-1:0] nb;
  logic                   nb_ok;
  logic                   in_chunk;
  logic                   wr_en;
  logic [NUM_FACES-1:0]   border;
  logic [NUM_FACES-1:0]   rest;
  logic [FACE_W-1:0]      f_sel;
  logic                   found;

  // Capture the word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      idx_r  <= in_index;
      type_r <= in_type;
    end
  end

  assign in_chunk = (32'(idx_r) < CHUNK_VOXELS);
  assign wr_en    = cmd.work && (cmd.step == '0) && (mode_r == MODE_WRITE) && in_chunk;

  assign nb    = $signed({2'b00, idx_r}) + NB_W'(nb_offset(cmd.step));
  assign nb_ok = !nb[NB_W-1] && (nb[NB_W-2:0] < (NB_W-1)'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= type_r;
    end
    if (cmd.work) begin
      rd_data <= mem[nb[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    prev_step <= cmd.step;
    prev_ok   <= nb_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_vld <= 1'b0;
    end else begin
      prev_vld <= cmd.work;
    end
  end

  // Sort each returned read into the center type or a neighbor-empty flag.
  always_ff @(posedge clk) begin
    if (prev_vld) begin
      if (prev_step == '0) begin
        center <= rd_data;
      end else begin
        empty[prev_step - STEP_W'(1)] <= !prev_ok || (rd_data == '0);
      end
    end
  end

  // Coordinate split by reciprocal multiply through registers: product, row, x and depth product, then y and z.
  always_ff @(posedge clk) begin
    prod_w <= PROD_W'(idx_r) * PROD_W'(RECIP_W);
    q_row  <= IDX_W'(prod_w >> DIV_SH);
    x_r    <= idx_r - IDX_W'(q_row * CHUNK_WIDTH);
    prod_d <= PROD_W'(q_row) * PROD_W'(RECIP_D);
    y_r    <= IDX_W'(prod_d >> DIV_SH);
    z_r    <= q_row - IDX_W'(y_r * CHUNK_DEPTH);
  end

  assign border[FACE_LEFT]   = (x_r == '0);
  assign border[FACE_RIGHT]  = (x_r == IDX_W'(CHUNK_WIDTH - 1));
  assign border[FACE_FRONT]  = (z_r == '0);
  assign border[FACE_BACK]   = (z_r == IDX_W'(CHUNK_DEPTH - 1));
  assign border[FACE_BOTTOM] = (y_r == IDX_W'(CHUNK_HEIGHT - 1));
  assign border[FACE_TOP]    = (y_r == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (cmd.finish) begin
      if ((mode_r == MODE_QUERY) && in_chunk && (center != '0)) begin
        pend <= border | empty;
      end else begin
        pend <= '0;
      end
    end else if (cmd.advance) begin
      pend <= rest;
    end
  end

  // Pick the lowest pending face.
  always_comb begin
    f_sel = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_FACES; i++) begin
      if (pend[i] && !found) begin
        f_sel = FACE_W'(i);
        found = 1'b1;
      end
    end
  end

  assign rest = found ? (pend & ~(NUM_FACES'(1) << f_sel)) : '0;

  always_comb begin
    texture_id = '0;
    if (found) begin
      if (center == TYPE_W'(3)) begin
        case (f_sel)
          FACE_BOTTOM: texture_id = TYPE_W'(0);
          FACE_TOP:    texture_id = TYPE_W'(1);
          default:     texture_id = TYPE_W'(2);
        endcase
      end else begin
        texture_id = center - TYPE_W'(1);
      end
    end
  end

  assign face_valid  = found;
  assign face_id     = f_sel;
  assign last_face   = (rest == '0);
  assign status.last = last_face;
  assign pos_x       = x_r[POS_W-1:0];
  assign pos_y       = y_r[POS_W-1:0];
  assign pos_z       = z_r[POS_W-1:0];

endmodule

// File: rtl/core/voxel_face_culling_unit.sv
// ----------------------------------------------------------------------------
// voxel_face_culling_unit
// Voxel chunk store with per-voxel open-face culling.
// ----------------------------------------------------------------------------
// Each accepted word runs through the read sequence: the store is read once
// for the voxel and once for each of its six neighbors, one read a cycle, then
// the last read lands and the face mask forms. Records then leave one per
// cycle while the sink is ready: one for a write, an empty voxel or a voxel
// with no open face, and up to six otherwise. The next word is accepted only
// after the last record is taken. Entries of the store that were never written
// read as garbage; the store has no reset.
module voxel_face_culling_unit
  import vfc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  vfc_in_if.sink    voxel_in,
  vfc_out_if.source face_out
);

  vfc_cmd_t    cmd;
  vfc_status_t status;

  vfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (voxel_in.valid),
    .in_ready  (voxel_in.ready),
    .out_valid (face_out.valid),
    .out_ready (face_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  vfc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_mode    (voxel_in.mode),
    .in_index   (voxel_in.voxel_index),
    .in_type    (voxel_in.voxel_type),
    .face_valid (face_out.face_valid),
    .pos_x      (face_out.pos_x),
    .pos_y      (face_out.pos_y),
    .pos_z      (face_out.pos_z),
    .face_id    (face_out.face_id),
    .texture_id (face_out.texture_id),
    .last_face  (face_out.last_face)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(voxel_in.ready && face_out.valid))
    else $error("input ready while a record is pending");

  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    (voxel_in.valid && voxel_in.ready) |=> !face_out.valid)
    else $error("record shown right after word accepted");

  a_invalid_last: assert property (@(posedge clk) disable iff (rst)
    (face_out.valid && !face_out.face_valid) |-> face_out.last_face)
    else $error("invalid record not marked last");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    (face_out.valid && face_out.face_valid) |->
      (face_out.face_id == FACE_LEFT || face_out.face_id == FACE_RIGHT ||
       face_out.face_id == FACE_FRONT || face_out.face_id == FACE_BACK ||
       face_out.face_id == FACE_BOTTOM || face_out.face_id == FACE_TOP))
    else $error("face id out of range");

endmodule

// File: verif/voxel_face_culling_unit_test.sv
// ----------------------------------------------------------------------------
// voxel_face_culling_unit_test
// Self-checking bench for the voxel face culler. Writes voxel types into the
// chunk store and queries voxels, with each query's center and every neighbor
// address inside the store written beforehand. A local predictor works out the
// face records of each accepted word, and a checker compares every record, in
// order and field by field. Both sides idle at random, and the sender also
// holds off until the block drains.
// ----------------------------------------------------------------------------
module voxel_face_culling_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vfc_pkg::*;

  localparam int GAP_MAX        = 12;
  localparam int RANDOM_ITEMS   = 145;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 24;

  localparam int WIDTH_I  = int'(CHUNK_WIDTH);
  localparam int DEPTH_I  = int'(CHUNK_DEPTH);
  localparam int HEIGHT_I = int'(CHUNK_HEIGHT);
  localparam int LAYER_I  = int'(LAYER);
  localparam int CHUNK_I  = int'(CHUNK_VOXELS);
  localparam int STORE_I  = int'(STORE_DEPTH);

  localparam logic [TYPE_W-1:0] EMPTY_TYPE  = 8'd0;
  localparam logic [TYPE_W-1:0] GRASS_TYPE  = 8'd3;
  localparam logic [TYPE_W-1:0] SIDE_TILE   = 8'd2;
  localparam logic [TYPE_W-1:0] BOTTOM_TILE = 8'd0;
  localparam logic [TYPE_W-1:0] TOP_TILE    = 8'd1;

  typedef struct packed {
    logic              face_valid;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [FACE_W-1:0] face_id;
    logic [TYPE_W-1:0] texture_id;
    logic              last_face;
  } face_rec_t;

  logic clk;
  logic rst;

  vfc_in_if  voxel_in();
  vfc_out_if face_out();

  voxel_face_culling_unit dut (
    .clk      (clk),
    .rst      (rst),
    .voxel_in (voxel_in),
    .face_out (face_out)
  );

  logic [TYPE_W-1:0] chunk_model [STORE_DEPTH];
  face_rec_t         pending_faces [$];
  int                probed_cells [$];
  int                fail_count;
  int                items_sent;
  int                idle_cycles;
  bit                src_burst;
  bit                snk_burst;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] cell_index(int x, int y, int z);
    return IDX_W'(x + z * WIDTH_I + y * LAYER_I);
  endfunction

  function automatic logic [TYPE_W-1:0] model_voxel(int addr);
    if (addr < 0 || addr >= STORE_I) return EMPTY_TYPE;
    return chunk_model[addr];
  endfunction

  function automatic logic [TYPE_W-1:0] face_texture(logic [TYPE_W-1:0] vtype,
                                                     logic [FACE_W-1:0] face);
    if (vtype == GRASS_TYPE) begin
      case (face)
        FACE_BOTTOM: return BOTTOM_TILE;
        FACE_TOP:    return TOP_TILE;
        default:     return SIDE_TILE;
      endcase
    end
    return vtype - 1'b1;
  endfunction

  function automatic face_rec_t make_rec(logic [IDX_W-1:0] idx, logic fv,
                                         logic [FACE_W-1:0] face,
                                         logic [TYPE_W-1:0] tex, logic last);
    face_rec_t r;
    r.face_valid = fv;
    r.pos_x      = POS_W'(int'(idx) % WIDTH_I);
    r.pos_y      = POS_W'(int'(idx) / LAYER_I);
    r.pos_z      = POS_W'((int'(idx) % LAYER_I) / WIDTH_I);
    r.face_id    = face;
    r.texture_id = tex;
    r.last_face  = last;
    return r;
  endfunction

  function automatic void predict_faces(logic mode, logic [IDX_W-1:0] idx,
                                        logic [TYPE_W-1:0] vtype);
    int                addr;
    int                x;
    int                y;
    int                z;
    int                f;
    int                n_open;
    int                n_put;
    logic [TYPE_W-1:0] center;
    logic              open_face [NUM_FACES];
    addr = int'(idx);
    if (mode == MODE_WRITE) begin
      if (addr < CHUNK_I && addr < STORE_I) chunk_model[addr] = vtype;
      pending_faces.insert(pending_faces.size(), make_rec(idx, 1'b0, FACE_LEFT, '0, 1'b1));
      return;
    end
    center = model_voxel(addr);
    if (addr >= CHUNK_I || center == EMPTY_TYPE) begin
      pending_faces.insert(pending_faces.size(), make_rec(idx, 1'b0, FACE_LEFT, '0, 1'b1));
      return;
    end
    x = addr % WIDTH_I;
    z = (addr % LAYER_I) / WIDTH_I;
    y = addr / LAYER_I;
    open_face[FACE_LEFT]   = (x == 0) || model_voxel(addr - 1) == EMPTY_TYPE;
    open_face[FACE_RIGHT]  = (x == WIDTH_I - 1) || model_voxel(addr + 1) == EMPTY_TYPE;
    open_face[FACE_FRONT]  = (z == 0) || model_voxel(addr - WIDTH_I) == EMPTY_TYPE;
    open_face[FACE_BACK]   = (z == DEPTH_I - 1) || model_voxel(addr + WIDTH_I) == EMPTY_TYPE;
    open_face[FACE_BOTTOM] = (y == HEIGHT_I - 1) || model_voxel(addr + LAYER_I) == EMPTY_TYPE;
    open_face[FACE_TOP]    = (y == 0) || model_voxel(addr - LAYER_I) == EMPTY_TYPE;
    n_open = 0;
    for (f = 0; f < NUM_FACES; f++) if (open_face[f]) n_open++;
    if (n_open == 0) begin
      pending_faces.insert(pending_faces.size(), make_rec(idx, 1'b0, FACE_LEFT, '0, 1'b1));
      return;
    end
    n_put = 0;
    for (f = 0; f < NUM_FACES; f++) begin
      if (open_face[f]) begin
        n_put++;
        pending_faces.insert(pending_faces.size(),
                             make_rec(idx, 1'b1, FACE_W'(f),
                                      face_texture(center, FACE_W'(f)),
                                      n_put == n_open));
      end
    end
  endfunction

  // -------------------------------------------------------------------------
  // Record checker and watchdog
  // -------------------------------------------------------------------------
  function automatic void check_field(string name, logic [TYPE_W-1:0] want,
                                      logic [TYPE_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_faces
    face_rec_t want;
    face_rec_t got;
    bit        in_fire;
    bit        out_fire;
    in_fire  = voxel_in.valid === 1'b1 && voxel_in.ready === 1'b1;
    out_fire = !rst && face_out.valid === 1'b1 && face_out.ready === 1'b1;
    if (out_fire) begin
      got.face_valid = face_out.face_valid;
      got.pos_x      = face_out.pos_x;
      got.pos_y      = face_out.pos_y;
      got.pos_z      = face_out.pos_z;
      got.face_id    = face_out.face_id;
      got.texture_id = face_out.texture_id;
      got.last_face  = face_out.last_face;
      if (pending_faces.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected record, expected none, got %h", $time, got);
      end else begin
        want = pending_faces.pop_front();
        check_field("face_valid", want.face_valid, got.face_valid);
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("pos_z", want.pos_z, got.pos_z);
        check_field("face_id", want.face_id, got.face_id);
        check_field("texture_id", want.texture_id, got.texture_id);
        check_field("last_face", want.last_face, got.last_face);
      end
    end
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sink side: stall a random number of cycles before taking each record.
  initial begin : drive_sink
    int stall;
    face_out.ready = 1'b0;
    forever begin
      stall = snk_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        @(negedge clk);
        face_out.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      face_out.ready <= 1'b1;
      do @(posedge clk); while (face_out.valid !== 1'b1 || rst);
    end
  end

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------
  // Leaves valid high after the handshake; the next call or release_bus
  // moves it at the following falling edge.
  task automatic send_word(logic mode, logic [IDX_W-1:0] idx, logic [TYPE_W-1:0] vtype);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      @(negedge clk);
      voxel_in.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    voxel_in.valid       <= 1'b1;
    voxel_in.mode        <= mode;
    voxel_in.voxel_index <= idx;
    voxel_in.voxel_type  <= vtype;
    do @(posedge clk); while (voxel_in.ready !== 1'b1);
    predict_faces(mode, idx, vtype);
    items_sent++;
  endtask

  task automatic release_bus();
    @(negedge clk);
    voxel_in.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_bus();
    while (pending_faces.size() != 0) @(posedge clk);
  endtask

  task automatic send_query(logic [IDX_W-1:0] idx);
    send_word(MODE_QUERY, idx, TYPE_W'($urandom));
  endtask

  function automatic logic [TYPE_W-1:0] rand_type();
    case ($urandom_range(0, 9))
      0, 1, 2: return EMPTY_TYPE;
      3, 4:    return GRASS_TYPE;
      5:       return 8'd1;
      6:       return 8'hFF;
      default: return TYPE_W'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic int pick_coord(int top);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return top - 1;
      default: return $urandom_range(0, top - 1);
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // Corner at the origin: left, front and top lie on the border.
  task automatic test_low_corner();
    send_word(MODE_WRITE, cell_index(0, 0, 0), GRASS_TYPE);
    send_word(MODE_WRITE, cell_index(1, 0, 0), 8'd5);
    send_word(MODE_WRITE, cell_index(0, 0, 1), EMPTY_TYPE);
    send_word(MODE_WRITE, cell_index(0, 1, 0), 8'd7);
    send_query(cell_index(0, 0, 0));
  endtask

  // Far corner: right, back and bottom on the border, center type on max value.
  task automatic test_high_corner();
    send_word(MODE_WRITE, cell_index(15, 15, 15), 8'hFF);
    send_word(MODE_WRITE, cell_index(14, 15, 15), EMPTY_TYPE);
    send_word(MODE_WRITE, cell_index(15, 15, 14), 8'd1);
    send_word(MODE_WRITE, cell_index(15, 14, 15), GRASS_TYPE);
    send_query(cell_index(15, 15, 15));
  endtask

  // Fully enclosed voxel, then the same voxel emptied, then one open side.
  task automatic test_enclosed_and_empty();
    send_word(MODE_WRITE, cell_index(8, 8, 8), GRASS_TYPE);
    send_word(MODE_WRITE, cell_index(7, 8, 8), 8'd1);
    send_word(MODE_WRITE, cell_index(9, 8, 8), 8'd2);
    send_word(MODE_WRITE, cell_index(8, 8, 7), 8'd9);
    send_word(MODE_WRITE, cell_index(8, 8, 9), 8'h80);
    send_word(MODE_WRITE, cell_index(8, 9, 8), 8'hFF);
    send_word(MODE_WRITE, cell_index(8, 7, 8), GRASS_TYPE);
    send_query(cell_index(8, 8, 8));
    wait_drained();
    send_word(MODE_WRITE, cell_index(8, 8, 8), EMPTY_TYPE);
    send_query(cell_index(8, 8, 8));
    send_word(MODE_WRITE, cell_index(8, 8, 8), 8'd42);
    send_word(MODE_WRITE, cell_index(7, 8, 8), EMPTY_TYPE);
    send_query(cell_index(8, 8, 8));
  endtask

  // Mostly clusters: write a voxel and its in-store neighbors in random order,
  // then query it. The rest re-queries a probed voxel and writes a stray cell, or scatters stray writes.
  task automatic test_random_clusters();
    int stop_at;
    int center;
    int prev_center;
    int cand;
    int i;
    int j;
    int tmp;
    int cells [$];
    int offs [NUM_FACES];
    offs[FACE_LEFT]   = -1;
    offs[FACE_RIGHT]  = 1;
    offs[FACE_FRONT]  = -WIDTH_I;
    offs[FACE_BACK]   = WIDTH_I;
    offs[FACE_BOTTOM] = LAYER_I;
    offs[FACE_TOP]    = -LAYER_I;
    prev_center = int'(cell_index(8, 8, 8));
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      src_burst = ($urandom_range(0, 3) == 0);
      snk_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          case ($urandom_range(0, 9))
            0, 1, 2: begin
              cand = prev_center + offs[$urandom_range(0, NUM_FACES - 1)];
              center = (cand >= 0 && cand < STORE_I) ? cand : prev_center;
            end
            3, 4:
              center = int'(cell_index(pick_coord(WIDTH_I), pick_coord(HEIGHT_I),
                                       pick_coord(DEPTH_I)));
            default:
              center = $urandom_range(0, STORE_I - 1);
          endcase
          cells.delete();
          cells.insert(cells.size(), center);
          for (i = 0; i < NUM_FACES; i++) begin
            cand = center + offs[i];
            if (cand >= 0 && cand < STORE_I) cells.insert(cells.size(), cand);
          end
          for (i = cells.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = cells[i];
            cells[i] = cells[j];
            cells[j] = tmp;
          end
          foreach (cells[k]) send_word(MODE_WRITE, IDX_W'(cells[k]), rand_type());
          send_query(IDX_W'(center));
          probed_cells.insert(probed_cells.size(), center);
          prev_center = center;
        end
        7, 8: begin
          if (probed_cells.size() > 0)
            send_query(IDX_W'(probed_cells[$urandom_range(0, probed_cells.size() - 1)]));
          send_word(MODE_WRITE, IDX_W'($urandom), rand_type());
        end
        default: begin
          // Broken cluster: scatter a few writes and never query them.
          center = $urandom_range(0, STORE_I - 1);
          repeat ($urandom_range(1, 3)) begin
            cand = center + offs[$urandom_range(0, NUM_FACES - 1)];
            if (cand >= 0 && cand < STORE_I)
              send_word(MODE_WRITE, IDX_W'(cand), rand_type());
          end
        end
      endcase
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    rst                  = 1'b1;
    voxel_in.valid       = 1'b0;
    voxel_in.mode        = MODE_WRITE;
    voxel_in.voxel_index = '0;
    voxel_in.voxel_type  = '0;
    fail_count           = 0;
    items_sent           = 0;
    idle_cycles          = 0;
    src_burst            = 1'b0;
    snk_burst            = 1'b0;
    foreach (chunk_model[i]) chunk_model[i] = EMPTY_TYPE;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_low_corner();
    test_high_corner();
    test_enclosed_and_empty();
    test_random_clusters();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
